FILE: src/jncu_pkg.sv
`default_nettype none
package jncu_pkg;

  typedef enum logic [3:0] {
    OP_I2L = 4'd0, OP_I2F = 4'd1, OP_I2D = 4'd2, OP_L2I = 4'd3,
    OP_L2F = 4'd4, OP_L2D = 4'd5, OP_F2I = 4'd6, OP_F2L = 4'd7,
    OP_F2D = 4'd8, OP_D2I = 4'd9, OP_D2L = 4'd10, OP_D2F = 4'd11,
    OP_I2B = 4'd12, OP_I2C = 4'd13, OP_I2S = 4'd14, OP_NONE = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    KIND_INT = 2'd0, KIND_LONG = 2'd1, KIND_FLOAT = 2'd2, KIND_DOUBLE = 2'd3
  } kind_t;

  // Result class decided in stage one
  typedef enum logic [1:0] {
    CLS_DIRECT = 2'd0, CLS_I2FP = 2'd1, CLS_FP2I = 2'd2, CLS_D2F = 2'd3
  } cls_t;

endpackage
`default_nettype wire

FILE: src/jvm_numeric_conversion_unit.sv
// Converts one JVM primitive value per request among int, long, float and
// double, or narrows an int to byte, char or short, with JVM rounding and
// saturation rules. Four register stages (decode, leading-one search,
// normalising shift, rounding and pack); a request enters every cycle while
// the pipeline is not stalled. A stall on the result side holds the whole
// pipeline; a request is taken while the last stage is empty or moving on.
`default_nettype none
module jvm_numeric_conversion_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_opcode,
  input  wire logic [63:0] in_operand_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_result_bits,
  output logic [1:0]       out_result_kind
);

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: decode -----------------
  logic        v1_r;
  logic [1:0]  cls1_r, cls1_nxt;
  logic [1:0]  kind1_r, kind1_nxt;
  logic [63:0] direct1_r, direct1_nxt;
  logic [63:0] mag1_r, mag1_nxt;     // integer magnitude or fp significand
  logic        sign1_r, sign1_nxt;
  logic        dbl1_r, dbl1_nxt;     // target double (i2fp) / 64-bit target (fp2i)
  logic        f2d1_r, f2d1_nxt;
  logic signed [12:0] e1_r, e1_nxt;  // unbiased exponent for fp-to-int sources; float biased exponent for d2f
  logic        zero1_r, zero1_nxt;   // fp2i gives zero / fp source zero
  logic        sat1_r, sat1_nxt;
  logic        spec1_r, spec1_nxt;   // d2f special result in direct1

  always_comb begin
    logic [63:0] x;
    logic [10:0] ex;
    logic [51:0] fr;
    logic        s, is_d, nan;
    logic [6:0]  nbits;
    x = 64'd0; ex = 11'd0; fr = 52'd0; s = 1'b0; is_d = 1'b0; nan = 1'b0;
    nbits = 7'd32;
    cls1_nxt = jncu_pkg::CLS_DIRECT;
    kind1_nxt = jncu_pkg::KIND_INT;
    direct1_nxt = 64'd0; mag1_nxt = 64'd0; sign1_nxt = 1'b0;
    dbl1_nxt = 1'b0; f2d1_nxt = 1'b0; e1_nxt = 13'sd0; zero1_nxt = 1'b0;
    sat1_nxt = 1'b0; spec1_nxt = 1'b0;
    unique case (jncu_pkg::op_t'(in_opcode))
      jncu_pkg::OP_I2L: begin
        direct1_nxt = {{32{in_operand_bits[31]}}, in_operand_bits[31:0]};
        kind1_nxt = jncu_pkg::KIND_LONG;
      end
      jncu_pkg::OP_L2I: direct1_nxt = {32'd0, in_operand_bits[31:0]};
      jncu_pkg::OP_I2B: direct1_nxt = {32'd0, {24{in_operand_bits[7]}}, in_operand_bits[7:0]};
      jncu_pkg::OP_I2C: direct1_nxt = {48'd0, in_operand_bits[15:0]};
      jncu_pkg::OP_I2S: direct1_nxt = {32'd0, {16{in_operand_bits[15]}},
                                       in_operand_bits[15:0]};
      jncu_pkg::OP_I2F, jncu_pkg::OP_I2D, jncu_pkg::OP_L2F, jncu_pkg::OP_L2D: begin
        if (in_opcode == jncu_pkg::OP_I2F || in_opcode == jncu_pkg::OP_I2D)
          x = {{32{in_operand_bits[31]}}, in_operand_bits[31:0]};
        else
          x = in_operand_bits;
        cls1_nxt  = jncu_pkg::CLS_I2FP;
        sign1_nxt = x[63];
        mag1_nxt  = x[63] ? (64'd0 - x) : x;
        dbl1_nxt  = (in_opcode == jncu_pkg::OP_I2D || in_opcode == jncu_pkg::OP_L2D);
        kind1_nxt = dbl1_nxt ? jncu_pkg::KIND_DOUBLE : jncu_pkg::KIND_FLOAT;
      end
      jncu_pkg::OP_F2I, jncu_pkg::OP_F2L, jncu_pkg::OP_D2I, jncu_pkg::OP_D2L: begin
        is_d = (in_opcode == jncu_pkg::OP_D2I || in_opcode == jncu_pkg::OP_D2L);
        if (is_d) begin
          s = in_operand_bits[63]; ex = in_operand_bits[62:52];
          fr = in_operand_bits[51:0];
          nan = (ex == 11'h7FF) && (fr != 52'd0);
          e1_nxt = $signed({2'b00, ex}) - 13'sd1023;
          mag1_nxt = {11'd0, 1'b1, fr};
        end else begin
          s = in_operand_bits[31]; ex = {3'd0, in_operand_bits[30:23]};
          fr = {in_operand_bits[22:0], 29'd0};
          nan = (ex == 11'h0FF) && (fr != 52'd0);
          e1_nxt = $signed({2'b00, ex}) - 13'sd127;
          mag1_nxt = {11'd0, 1'b1, fr};
        end
        dbl1_nxt  = (in_opcode == jncu_pkg::OP_F2L || in_opcode == jncu_pkg::OP_D2L);
        nbits     = dbl1_nxt ? 7'd64 : 7'd32;
        cls1_nxt  = jncu_pkg::CLS_FP2I;
        kind1_nxt = dbl1_nxt ? jncu_pkg::KIND_LONG : jncu_pkg::KIND_INT;
        sign1_nxt = s;
        zero1_nxt = nan || (ex == 11'd0) || (e1_nxt < 13'sd0);
        sat1_nxt  = !zero1_nxt && (e1_nxt >= $signed({6'd0, nbits}) - 13'sd1);
      end
      jncu_pkg::OP_F2D: begin
        // reuse the int-to-fp path for zero and subnormal floats; others are direct
        s = in_operand_bits[31]; ex = {3'd0, in_operand_bits[30:23]};
        kind1_nxt = jncu_pkg::KIND_DOUBLE;
        if (ex == 11'h0FF) begin
          direct1_nxt = {s, 11'h7FF, (in_operand_bits[22:0] != 23'd0),
                         in_operand_bits[21:0], 29'd0};
        end else if (ex == 11'd0) begin
          cls1_nxt  = jncu_pkg::CLS_I2FP;
          f2d1_nxt  = 1'b1;
          dbl1_nxt  = 1'b1;
          sign1_nxt = s;
          mag1_nxt  = {41'd0, in_operand_bits[22:0]};
        end else begin
          direct1_nxt = {s, ex + 11'd896, in_operand_bits[22:0], 29'd0};
        end
      end
      jncu_pkg::OP_D2F: begin
        s = in_operand_bits[63]; ex = in_operand_bits[62:52];
        fr = in_operand_bits[51:0];
        kind1_nxt = jncu_pkg::KIND_FLOAT;
        cls1_nxt  = jncu_pkg::CLS_D2F;
        sign1_nxt = s;
        mag1_nxt  = {11'd0, 1'b1, fr};
        e1_nxt    = $signed({2'b00, ex}) - 13'sd896;   // float biased exponent
        zero1_nxt = (ex == 11'd0);
        if (ex == 11'h7FF) begin
          spec1_nxt = 1'b1;
          direct1_nxt = (fr == 52'd0) ? {32'd0, s, 31'h7F800000}
                                      : {32'd0, s, 8'hFF, fr[51:29] | 23'h400000};
        end
      end
      default: ;
    endcase
  end

  // ---------------- stage 2: leading-one position -----------------
  logic        v2_r;
  logic [1:0]  cls2_r, kind2_r;
  logic [63:0] direct2_r, mag2_r;
  logic        sign2_r, dbl2_r, f2d2_r, zero2_r, sat2_r, spec2_r;
  logic signed [12:0] e2_r;
  logic [5:0]  top2_r, top2_nxt;

  always_comb begin
    top2_nxt = 6'd0;
    for (int i = 0; i < 64; i++)
      if (mag1_r[i]) top2_nxt = 6'(i);
  end

  // ---------------- stage 3: normalise / align -----------------
  logic        v3_r;
  logic [1:0]  cls3_r, kind3_r;
  logic [63:0] direct3_r;
  logic        sign3_r, dbl3_r, f2d3_r, zero3_r, sat3_r, spec3_r;
  logic signed [12:0] e3_r, e3_nxt;
  logic [63:0] sh3_r, sh3_nxt;   // normalised (bit 63 lead) or integer magnitude
  logic        stk3_r, stk3_nxt; // sticky for d2f subnormal path

  always_comb begin
    logic [6:0] rs;
    logic [63:0] lost;
    sh3_nxt = 64'd0; stk3_nxt = 1'b0; e3_nxt = e2_r; rs = 7'd0; lost = 64'd0;
    unique case (jncu_pkg::cls_t'(cls2_r))
      jncu_pkg::CLS_I2FP: begin
        sh3_nxt = mag2_r << (6'd63 - top2_r);
        e3_nxt  = $signed({7'd0, top2_r});
      end
      jncu_pkg::CLS_FP2I: begin
        // value = sig * 2^(e-52), 0 <= e <= 62 here when used
        if (e2_r >= 13'sd52) sh3_nxt = mag2_r << (6'(e2_r - 13'sd52));
        else                 sh3_nxt = mag2_r >> (6'(13'sd52 - e2_r));
      end
      jncu_pkg::CLS_D2F: begin
        // place significand at bits 63..11, shift right for subnormals
        if (e2_r >= 13'sd1) sh3_nxt = mag2_r << 11;
        else begin
          rs = (e2_r < -13'sd63) ? 7'd64 : 7'(13'sd1 - e2_r);
          lost = (rs >= 7'd64) ? (mag2_r << 11) : ((mag2_r << 11) << (7'd64 - rs));
          sh3_nxt = (rs >= 7'd64) ? 64'd0 : ((mag2_r << 11) >> rs[5:0]);
          stk3_nxt = (lost != 64'd0);
        end
      end
      default: ;
    endcase
  end

  // ---------------- stage 4: round and pack -----------------
  logic        v4_r;
  logic [63:0] res4_r, res4_nxt;
  logic [1:0]  kind4_r;

  always_comb begin
    logic [52:0] keep;
    logic        g, st;
    logic [11:0] ebias;
    logic [63:0] m;
    res4_nxt = direct3_r; keep = 53'd0; g = 1'b0; st = 1'b0; ebias = 12'd0; m = 64'd0;
    unique case (jncu_pkg::cls_t'(cls3_r))
      jncu_pkg::CLS_DIRECT: ;
      jncu_pkg::CLS_I2FP: begin
        if (zero3_r || sh3_r == 64'd0) begin
          res4_nxt = f2d3_r ? {sign3_r, 63'd0} : 64'd0;
        end else if (dbl3_r) begin
          keep = sh3_r[63:11]; g = sh3_r[10]; st = |sh3_r[9:0];
          if (g && (st || keep[0])) keep = keep + 53'd1;
          ebias = f2d3_r ? (12'(e3_r) + 12'd874) : (12'(e3_r) + 12'd1023);
          // a carry out of the significand bumps the exponent
          if (keep == 53'd0)
            ebias = ebias + 12'd1;
          res4_nxt = {sign3_r, ebias[10:0], keep[51:0]};
        end else begin
          keep = {29'd0, sh3_r[63:40]}; g = sh3_r[39]; st = |sh3_r[38:0];
          if (g && (st || keep[0])) keep = keep + 53'd1;
          ebias = 12'(e3_r) + 12'd127;
          if (keep[24]) begin ebias = ebias + 12'd1; keep = keep >> 1; end
          res4_nxt = {32'd0, sign3_r, ebias[7:0], keep[22:0]};
        end
      end
      jncu_pkg::CLS_FP2I: begin
        if (zero3_r) res4_nxt = 64'd0;
        else if (sat3_r)
          res4_nxt = dbl3_r ? (sign3_r ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF)
                            : (sign3_r ? 64'h0000000080000000 : 64'h000000007FFFFFFF);
        else begin
          m = sign3_r ? (64'd0 - sh3_r) : sh3_r;
          res4_nxt = dbl3_r ? m : {32'd0, m[31:0]};
        end
      end
      jncu_pkg::CLS_D2F: begin
        if (spec3_r) res4_nxt = direct3_r;
        else if (zero3_r) res4_nxt = {32'd0, sign3_r, 31'd0};
        else if (e3_r >= 13'sd255) res4_nxt = {32'd0, sign3_r, 31'h7F800000};
        else if (e3_r >= 13'sd1) begin
          keep = {29'd0, sh3_r[63:40]}; g = sh3_r[39]; st = |sh3_r[38:0];
          if (g && (st || keep[0])) keep = keep + 53'd1;
          ebias = 12'(e3_r);
          if (keep[24]) begin ebias = ebias + 12'd1; keep = keep >> 1; end
          res4_nxt = (ebias >= 12'd255) ? {32'd0, sign3_r, 31'h7F800000}
                                        : {32'd0, sign3_r, ebias[7:0], keep[22:0]};
        end else begin
          // subnormal: field = bits 63..40 after right shift by (1-e)
          keep = {29'd0, sh3_r[63:40]}; g = sh3_r[39];
          st = (|sh3_r[38:0]) || stk3_r;
          if (g && (st || keep[0])) keep = keep + 53'd1;
          res4_nxt = {32'd0, sign3_r, 7'd0, keep[23:0]};
        end
      end
      default: ;
    endcase
  end

  // ---------------- pipeline registers -----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls1_r <= cls1_nxt; kind1_r <= kind1_nxt; direct1_r <= direct1_nxt;
      mag1_r <= mag1_nxt; sign1_r <= sign1_nxt; dbl1_r <= dbl1_nxt;
      f2d1_r <= f2d1_nxt; e1_r <= e1_nxt; zero1_r <= zero1_nxt;
      sat1_r <= sat1_nxt; spec1_r <= spec1_nxt;
      cls2_r <= cls1_r; kind2_r <= kind1_r; direct2_r <= direct1_r;
      mag2_r <= mag1_r; sign2_r <= sign1_r; dbl2_r <= dbl1_r; f2d2_r <= f2d1_r;
      e2_r <= e1_r; zero2_r <= zero1_r; sat2_r <= sat1_r; spec2_r <= spec1_r;
      top2_r <= top2_nxt;
      cls3_r <= cls2_r; kind3_r <= kind2_r; direct3_r <= direct2_r;
      sign3_r <= sign2_r; dbl3_r <= dbl2_r; f2d3_r <= f2d2_r; zero3_r <= zero2_r;
      sat3_r <= sat2_r; spec3_r <= spec2_r; e3_r <= e3_nxt; sh3_r <= sh3_nxt;
      stk3_r <= stk3_nxt;
      res4_r <= res4_nxt; kind4_r <= kind3_r;
    end
  end

  assign out_valid       = v4_r;
  assign out_result_bits = res4_r;
  assign out_result_kind = kind4_r;

  // ---------------- assertions -----------------
  a_int_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == jncu_pkg::KIND_INT ||
                  out_result_kind == jncu_pkg::KIND_FLOAT)
    |-> out_result_bits[63:32] == 32'd0) else $error("upper half not clear");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_bits))
    else $error("result dropped under stall");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r) else $error("request lost in stage one");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("stalled with empty output");

endmodule
`default_nettype wire
